// ----- sv/bitmap_slab_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// Slab allocator assertion macros
// Shorthand for clocked implication checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_SLAB_ALLOCATOR_ASSERT_SVH
`define BITMAP_SLAB_ALLOCATOR_ASSERT_SVH

// Same-cycle implication
`define BSA_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slab allocator check failed");

// Next-cycle implication
`define BSA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slab allocator check failed");

`endif

// ----- sv/bsa_pkg.sv -----
// ----------------------------------------------------------------------------
// Slab allocator package
// Geometry constants, command and status codes, bitmap reset pattern.
// ----------------------------------------------------------------------------
package bsa_pkg;

   localparam int SLAB_BYTES_LOG2 = 12;
   localparam int NUM_CLASSES     = 8;

   localparam int SLAB_WORDS   = 1 << (SLAB_BYTES_LOG2 - 6);
   localparam int WORD_IDX_W   = SLAB_BYTES_LOG2 - 6;
   localparam int SLAB_IDX_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int MEM_AW       = SLAB_IDX_W + WORD_IDX_W;
   localparam int MEM_DEPTH    = NUM_CLASSES * SLAB_WORDS;
   localparam int OBJ_W        = WORD_IDX_W + 5;

   localparam logic [31:0] REGION_BYTES = 32'(NUM_CLASSES) << SLAB_BYTES_LOG2;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_BAD_CLASS = 2'd2;
   localparam logic [1:0] STATUS_OUTSIDE   = 2'd3;

   typedef struct packed {
      logic       found;
      logic [4:0] index;
   } ffs_result_type;

   // Number of bitmap words scanned for class k (1-based)
   function automatic logic [WORD_IDX_W:0] words_of_class(logic [3:0] k);
      logic [31:0] n;
      logic [31:0] w;
      n = (32'(k) > 32'(SLAB_BYTES_LOG2)) ? 32'd0
                                           : (32'd1 << (32'(SLAB_BYTES_LOG2) - 32'(k)));
      w = (n + 32'd31) >> 5;
      if (w > 32'(SLAB_WORDS)) begin
         w = 32'(SLAB_WORDS);
      end
      return (WORD_IDX_W + 1)'(w);
   endfunction

   // Reset contents of one bitmap word: bitmap-reserved and padding used
   function automatic logic [31:0] init_word(logic [SLAB_IDX_W-1:0] slab,
                                             logic [WORD_IDX_W-1:0] word);
      logic [31:0] k;
      logic [31:0] n;
      logic [31:0] b;
      logic [31:0] r;
      logic [31:0] j;
      logic [31:0] res;
      k = 32'(slab) + 32'd1;
      n = (k > 32'(SLAB_BYTES_LOG2)) ? 32'd0
                                      : (32'd1 << (32'(SLAB_BYTES_LOG2) - k));
      b = (n + 32'd31) & ~32'd31;
      r = (b + (32'd8 << k) - 32'd1) >> (k + 32'd3);
      res = '0;
      for (int i = 0; i < 32; i++) begin
         j = (32'(word) << 5) + 32'(i);
         if (j < b) begin
            res[31 - i] = (j < r) || (j >= n);
         end
      end
      return res;
   endfunction

endpackage

// ----- sv/bsa_ffs.sv -----
// ----------------------------------------------------------------------------
// Slab allocator first-free search
// Finds the lowest-numbered set bit of a word, numbered MSB first.
// ----------------------------------------------------------------------------
module bsa_ffs
   import bsa_pkg::*;
(
   input  logic [31:0]    free_bits,
   output ffs_result_type result
);

   always_comb begin
      result.found = |free_bits;
      result.index = '0;
      // descending, so the lowest object number wins
      for (int i = 31; i >= 0; i--) begin
         if (free_bits[31 - i]) begin
            result.index = 5'(i);
         end
      end
   end

endmodule

// ----- sv/bitmap_slab_allocator.sv -----
// ----------------------------------------------------------------------------
// Bitmap slab allocator
// Power-of-two size class allocator over one region of equal slabs.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel: start/busy. A request is taken on a clock edge with
//    start high and busy low; req_cmd selects allocate or free.
//  - Response: rsp_strobe is high for exactly one cycle per request, with
//    rsp_object_address and rsp_status. The receiver cannot stall it.
//  - csr_*: writes region_base; always ready. The user must write it only
//    while idle; the block itself does not enforce this.
//  - Allocate, from the taking edge: per bitmap word scanned, a memory read
//    then a first-free search; then bitmap write-back, address add, response.
//    The scan stops at the first word with a free object. Bad class and
//    class with no objects: answered straight from idle.
//  - Free: offset subtract, range check and read, write-back, response.
//    Outside region: answered after the range check.
//  - One request at a time; busy drops in the cycle the response is shown,
//    so the next request can be taken on the edge that ends it. A bad class
//    is answered straight from idle and never raises busy.
//  - Reset: a clearing pass writes the reset pattern into the bitmap
//    memory, one word a cycle, all MEM_DEPTH words (512 here); busy is high
//    throughout and region_base returns to 0.
// ----------------------------------------------------------------------------
module bitmap_slab_allocator
   import bsa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [3:0]  req_size_class,
   input  logic [31:0] req_free_address,
   // response
   output logic        rsp_strobe,
   output logic [31:0] rsp_object_address,
   output logic [1:0]  rsp_status,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_wdata
);

   localparam logic [3:0] ST_INIT   = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_A_RD   = 4'd2;
   localparam logic [3:0] ST_A_CHK  = 4'd3;
   localparam logic [3:0] ST_A_MARK = 4'd4;
   localparam logic [3:0] ST_A_ADDR = 4'd5;
   localparam logic [3:0] ST_F_OFF  = 4'd6;
   localparam logic [3:0] ST_F_CHK  = 4'd7;
   localparam logic [3:0] ST_F_WR   = 4'd8;

   // control state
   logic [3:0]            state_ff,      state_in;
   logic [MEM_AW-1:0]     init_cnt_ff,   init_cnt_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [31:0]           region_base_ff, region_base_in;

   // working payload
   logic [3:0]            class_ff,    class_in;
   logic [SLAB_IDX_W-1:0] slab_ff,     slab_in;
   logic [WORD_IDX_W:0]   word_ff,     word_in;
   logic [WORD_IDX_W:0]   word_lim_ff, word_lim_in;
   logic [4:0]            bitpos_ff,   bitpos_in;
   logic [31:0]           work_ff,     work_in;
   logic [31:0]           rsp_addr_ff, rsp_addr_in;
   logic [1:0]            rsp_stat_ff, rsp_stat_in;

   // bitmap memory
   logic [31:0]           bitmap_mem_ff [MEM_DEPTH];
   logic [31:0]           mem_q_ff;
   logic                  rd_en;
   logic [MEM_AW-1:0]     rd_addr;
   logic                  wr_en;
   logic [MEM_AW-1:0]     wr_addr;
   logic [31:0]           wr_data;

   // shared adder
   logic [31:0]           add_a;
   logic [31:0]           add_b;
   logic                  add_cin;
   logic [31:0]           add_sum;

   // free decode, first-free search
   logic [SLAB_IDX_W-1:0]      f_slab;
   logic [SLAB_BYTES_LOG2-1:0] f_obj;
   logic [WORD_IDX_W:0]        class_words;
   logic [WORD_IDX_W:0]        word_next;
   logic [31:0]                bit_mask;
   ffs_result_type             ffs_res;

   assign busy               = (state_ff != ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_object_address = rsp_addr_ff;
   assign rsp_status         = rsp_stat_ff;

   assign class_words = words_of_class(req_size_class);
   assign word_next   = word_ff + 1'b1;
   assign bit_mask    = 32'h8000_0000 >> bitpos_ff;

   // offset in work_ff is below the region size when this is used
   assign f_slab = work_ff[SLAB_BYTES_LOG2 +: SLAB_IDX_W];
   assign f_obj  = work_ff[SLAB_BYTES_LOG2-1:0] >> ({1'b0, f_slab} + 1'b1);

   bsa_ffs u_ffs (
      .free_bits (~mem_q_ff),
      .result    (ffs_res)
   );

   // One adder serves offset, slab base and object offset
   always_comb begin
      add_a   = work_ff;
      add_b   = '0;
      add_cin = 1'b0;
      case (state_ff)
         ST_F_OFF: begin
            add_b   = ~region_base_ff;
            add_cin = 1'b1;
         end
         ST_A_MARK: begin
            add_a = region_base_ff;
            add_b = 32'(slab_ff) << SLAB_BYTES_LOG2;
         end
         ST_A_ADDR: begin
            add_b = 32'({word_ff[WORD_IDX_W-1:0], bitpos_ff}) << class_ff;
         end
         default: begin
         end
      endcase
   end

   assign add_sum = add_a + add_b + 32'(add_cin);

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      init_cnt_in    = init_cnt_ff;
      rsp_strobe_in  = 1'b0;
      region_base_in = region_base_ff;
      class_in       = class_ff;
      slab_in        = slab_ff;
      word_in        = word_ff;
      word_lim_in    = word_lim_ff;
      bitpos_in      = bitpos_ff;
      work_in        = work_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_stat_in    = rsp_stat_ff;
      rd_en          = 1'b0;
      rd_addr        = {slab_ff, word_ff[WORD_IDX_W-1:0]};
      wr_en          = 1'b0;
      wr_addr        = {slab_ff, word_ff[WORD_IDX_W-1:0]};
      wr_data        = mem_q_ff | bit_mask;

      if (csr_valid && csr_ready) begin
         region_base_in = csr_wdata;
      end

      unique case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = init_cnt_ff;
            wr_data = init_word(init_cnt_ff[MEM_AW-1:WORD_IDX_W],
                                init_cnt_ff[WORD_IDX_W-1:0]);
            init_cnt_in = init_cnt_ff + 1'b1;
            if (init_cnt_ff == MEM_AW'(MEM_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               class_in    = req_size_class;
               slab_in     = SLAB_IDX_W'(req_size_class - 4'd1);
               word_in     = '0;
               word_lim_in = class_words;
               work_in     = req_free_address;
               rsp_addr_in = '0;
               if (req_cmd == CMD_FREE) begin
                  state_in = ST_F_OFF;
               end else if (req_size_class == 4'd0 ||
                            32'(req_size_class) > 32'(NUM_CLASSES)) begin
                  rsp_stat_in   = STATUS_BAD_CLASS;
                  rsp_strobe_in = 1'b1;
               end else if (class_words == '0) begin
                  rsp_stat_in   = STATUS_FULL;
                  rsp_strobe_in = 1'b1;
               end else begin
                  state_in = ST_A_RD;
               end
            end
         end
         ST_A_RD: begin
            rd_en    = 1'b1;
            state_in = ST_A_CHK;
         end
         ST_A_CHK: begin
            if (ffs_res.found) begin
               bitpos_in = ffs_res.index;
               state_in  = ST_A_MARK;
            end else if (word_next == word_lim_ff) begin
               rsp_stat_in   = STATUS_FULL;
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               word_in  = word_next;
               state_in = ST_A_RD;
            end
         end
         ST_A_MARK: begin
            wr_en    = 1'b1;
            work_in  = add_sum;
            state_in = ST_A_ADDR;
         end
         ST_A_ADDR: begin
            rsp_addr_in   = add_sum;
            rsp_stat_in   = STATUS_OK;
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_F_OFF: begin
            work_in  = add_sum;
            state_in = ST_F_CHK;
         end
         ST_F_CHK: begin
            if (work_ff >= REGION_BYTES) begin
               rsp_stat_in   = STATUS_OUTSIDE;
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               slab_in   = f_slab;
               word_in   = {1'b0, f_obj[5 +: WORD_IDX_W]};
               bitpos_in = f_obj[4:0];
               rd_en     = 1'b1;
               rd_addr   = {f_slab, f_obj[5 +: WORD_IDX_W]};
               state_in  = ST_F_WR;
            end
         end
         ST_F_WR: begin
            wr_en         = 1'b1;
            wr_data       = mem_q_ff & ~bit_mask;
            rsp_stat_in   = STATUS_OK;
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         init_cnt_ff    <= '0;
         rsp_strobe_ff  <= 1'b0;
         region_base_ff <= '0;
      end else begin
         state_ff       <= state_in;
         init_cnt_ff    <= init_cnt_in;
         rsp_strobe_ff  <= rsp_strobe_in;
         region_base_ff <= region_base_in;
      end
   end

   always_ff @(posedge clock) begin
      class_ff    <= class_in;
      slab_ff     <= slab_in;
      word_ff     <= word_in;
      word_lim_ff <= word_lim_in;
      bitpos_ff   <= bitpos_in;
      work_ff     <= work_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   // Bitmap memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bitmap_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= bitmap_mem_ff[rd_addr];
      end
   end

endmodule

// ----- sv/bsa_checker.sv -----
// ----------------------------------------------------------------------------
// Slab allocator port checker
// Watches the top-level ports and flags request/response slips.
// ----------------------------------------------------------------------------
`include "bitmap_slab_allocator_assert.svh"

module bsa_checker
   import bsa_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [31:0] rsp_object_address,
   input logic [1:0]  rsp_status
);

   logic accepted;
   logic failed;
   logic bad_class_rsp;

   assign accepted      = start && !busy;
   assign failed        = rsp_strobe && (rsp_status != STATUS_OK);
   assign bad_class_rsp = rsp_strobe && (rsp_status == STATUS_BAD_CLASS);

   // a taken request either keeps the block busy or answers at once
   `BSA_ASSERT_NEXT(a_req_progress, clock, reset, accepted, busy || rsp_strobe)

   // no response without an outstanding request
   `BSA_ASSERT_SAME(a_rsp_has_req, clock, reset, rsp_strobe, $past(busy) || $past(accepted))

   // failed requests never hand out an address
   `BSA_ASSERT_SAME(a_fail_no_addr, clock, reset, failed, rsp_object_address == 32'd0)

   // bad class is answered in the cycle after the request
   `BSA_ASSERT_SAME(a_bad_class_fast, clock, reset, bad_class_rsp, $past(accepted))

endmodule

bind bitmap_slab_allocator bsa_checker u_bsa_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_strobe         (rsp_strobe),
   .rsp_object_address (rsp_object_address),
   .rsp_status         (rsp_status)
);

// ----- dv/bitmap_slab_allocator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitmap slab allocator testbench
// Drives allocate and free requests through the start/busy port and checks
// every response against an in-bench model of the slab bitmaps. Runs a short
// directed sequence, then random phases under several region bases and
// sender idle rates.
// ----------------------------------------------------------------------------
module bitmap_slab_allocator_tb;
   import bsa_pkg::*;

   localparam int PHASES        = 5;
   localparam int PHASE_ITEMS   = 255;
   // Longest allocate, a scan over every word of a slab, with some margin
   localparam int SETTLE_CYCLES = 2 * SLAB_WORDS + 12;
   localparam int TIMEOUT_NS    = 15_000_000;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      logic        cmd;
      logic [3:0]  size_class;
      logic [31:0] free_address;
   } request_type;

   typedef struct {
      logic [31:0] object_address;
      logic [1:0]  status;
   } response_type;

   // One allocated object: slab index and object number within it
   typedef struct {
      int unsigned slab;
      int unsigned obj;
   } slot_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_cmd = CMD_ALLOC;
   logic [3:0]  req_size_class = '0;
   logic [31:0] req_free_address = '0;
   logic        rsp_strobe;
   logic [31:0] rsp_object_address;
   logic [1:0]  rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_wdata = '0;

   // Model state: bitmap per slab (1 = used) and the region base
   logic [31:0] bitmap_model [NUM_CLASSES][SLAB_WORDS];
   logic [31:0] base_model = '0;

   request_type  pending_requests[$];
   response_type expected_responses[$];
   slot_type     live_objects[$];     // objects handed out, candidates for free
   int unsigned  sender_idle_pct = 0;
   int unsigned  mismatch_count  = 0;

   always #6 clock = ~clock;

   bitmap_slab_allocator DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_size_class     (req_size_class),
      .req_free_address   (req_free_address),
      .rsp_strobe         (rsp_strobe),
      .rsp_object_address (rsp_object_address),
      .rsp_status         (rsp_status),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_wdata          (csr_wdata)
   );

   // Works out the response to one request and updates the bitmap model.
   // Allocate takes the lowest free object, MSB first within each word.
   function automatic response_type serve_request(request_type rq);
      response_type rs;
      slot_type     sl;
      int unsigned  slab;
      int unsigned  objs;
      int unsigned  words;
      int unsigned  pos;
      logic [31:0]  offset;
      logic [31:0]  free_bits;
      bit           found;
      rs.object_address = '0;
      rs.status         = STATUS_OK;
      if (rq.cmd == CMD_ALLOC) begin
         if (rq.size_class == 0 || rq.size_class > NUM_CLASSES) begin
            rs.status = STATUS_BAD_CLASS;
         end else begin
            slab  = rq.size_class - 1;
            objs  = (rq.size_class > SLAB_BYTES_LOG2) ? 0
                                                      : (1 << (SLAB_BYTES_LOG2 - rq.size_class));
            words = (objs + 31) >> 5;
            found = 1'b0;
            for (int u = 0; u < words && u < SLAB_WORDS && !found; u++) begin
               free_bits = ~bitmap_model[slab][u];
               if (free_bits != 0) begin
                  pos = 0;
                  while (!free_bits[31 - pos]) pos++;
                  bitmap_model[slab][u][31 - pos] = 1'b1;
                  pos += u * 32;
                  rs.object_address = base_model + (slab << SLAB_BYTES_LOG2)
                                    + (pos << rq.size_class);
                  found = 1'b1;
                  sl.slab = slab;
                  sl.obj  = pos;
                  live_objects.push_back(sl);
               end
            end
            // no free object left in the slab
            if (!found) rs.status = STATUS_FULL;
         end
      end else begin
         // offset wraps modulo 2^32, so a region across zero still works
         offset = rq.free_address - base_model;
         if (offset >= REGION_BYTES) begin
            rs.status = STATUS_OUTSIDE;
         end else begin
            slab = offset >> SLAB_BYTES_LOG2;
            // low bits below the object size drop out here
            pos  = (offset & ((1 << SLAB_BYTES_LOG2) - 1)) >> (slab + 1);
            bitmap_model[slab][(pos >> 5) % SLAB_WORDS][31 - (pos % 32)] = 1'b0;
         end
      end
      return rs;
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
   endtask

   task automatic queue_request(input logic cmd, input logic [3:0] cls,
                                input logic [31:0] addr);
      request_type rq;
      rq.cmd          = cmd;
      rq.size_class   = cls;
      rq.free_address = addr;
      pending_requests.push_back(rq);
   endtask

   task automatic write_region_base(input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      base_model = value;
      csr_valid <= 1'b0;
   endtask

   // Wait until every queued request has been taken and answered
   task automatic drain_requests();
      while (pending_requests.size() != 0 || start || expected_responses.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Driver: a request is taken on an edge with start high and busy low.
   // The model is stepped at that edge, from the fields then on the port.
   always @(posedge clock) begin : drive_requests
      request_type  taken;
      response_type rs;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            taken.cmd          = req_cmd;
            taken.size_class   = req_size_class;
            taken.free_address = req_free_address;
            rs = serve_request(taken);
            expected_responses.push_back(rs);
         end
         if (!start || !busy) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               taken = pending_requests.pop_front();
               start            <= 1'b1;
               req_cmd          <= taken.cmd;
               req_size_class   <= taken.size_class;
               req_free_address <= taken.free_address;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: responses cannot be held off, one strobe per request
   always @(posedge clock) begin : check_responses
      response_type exp_rs;
      if (!reset && rsp_strobe) begin
         if (expected_responses.size() == 0) begin
            flag_mismatch($sformatf("response with none pending: addr %h status %0d",
                                    rsp_object_address, rsp_status));
         end else begin
            exp_rs = expected_responses.pop_front();
            if (rsp_object_address !== exp_rs.object_address)
               flag_mismatch($sformatf("object_address expected %h actual %h",
                                       exp_rs.object_address, rsp_object_address));
            if (rsp_status !== exp_rs.status)
               flag_mismatch($sformatf("status expected %0d actual %0d (addr %h)",
                                       exp_rs.status, rsp_status, exp_rs.object_address));
         end
      end
   end

   initial begin : stimulus
      request_type rq;
      slot_type    sl;
      int unsigned roll;
      int unsigned pick;
      int unsigned idx;
      int unsigned k;
      int unsigned n;
      int unsigned b;
      int unsigned r;
      logic [31:0] last_obj_addr;
      logic [31:0] phase_bases [PHASES];
      int unsigned phase_idle  [PHASES];

      // Reset pattern: bitmap-reserved objects and padding used, rest free
      for (int s = 0; s < NUM_CLASSES; s++) begin
         k = s + 1;
         n = (k > SLAB_BYTES_LOG2) ? 0 : (1 << (SLAB_BYTES_LOG2 - k));
         b = (n + 31) & ~32'd31;
         r = (b + (8 << k) - 1) / (8 << k);
         for (int w = 0; w < SLAB_WORDS; w++) bitmap_model[s][w] = '0;
         for (int j = 0; j < b; j++)
            bitmap_model[s][j / 32][31 - (j % 32)] = (j < r) || (j >= n);
      end

      phase_bases[0] = 32'h0000_0000;  phase_idle[0] = 0;
      phase_bases[1] = 32'hFFFF_FFFF;  phase_idle[1] = 85;
      phase_bases[2] = $urandom();     phase_idle[2] = 38;
      phase_bases[3] = 32'hFFFF_F000;  phase_idle[3] = 0;   // region wraps past zero
      phase_bases[4] = $urandom();     phase_idle[4] = 85;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part, region base at its reset value of zero
      queue_request(CMD_ALLOC, 4'd0,  32'hFFFF_FFFF);   // class zero
      queue_request(CMD_ALLOC, 4'd15, 32'h0000_0000);   // class far too large
      queue_request(CMD_ALLOC, 4'(NUM_CLASSES + 1), $urandom());
      queue_request(CMD_ALLOC, 4'd1, $urandom());       // first past reserved objects
      queue_request(CMD_ALLOC, 4'(NUM_CLASSES - 1), $urandom());
      // Largest class: take every free object, then one more for a full slab
      for (int i = 0; i < 16; i++) queue_request(CMD_ALLOC, 4'(NUM_CLASSES), $urandom());
      // Release a bitmap-reserved object of the first slab
      queue_request(CMD_FREE, 4'd15, 32'h0000_0000);
      queue_request(CMD_FREE, 4'd0, REGION_BYTES);      // just past the region
      // Last object of the largest class, unaligned, then freed twice
      last_obj_addr = ((NUM_CLASSES - 1) << SLAB_BYTES_LOG2)
                    + (((1 << (SLAB_BYTES_LOG2 - NUM_CLASSES)) - 1) << NUM_CLASSES);
      queue_request(CMD_FREE, 4'($urandom()), last_obj_addr + 32'h1F);
      queue_request(CMD_FREE, 4'($urandom()), last_obj_addr);
      drain_requests();

      for (int p = 0; p < PHASES; p++) begin
         write_region_base(phase_bases[p]);
         sender_idle_pct = phase_idle[p];
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Generate close to use so frees see recent allocations
            while (pending_requests.size() >= 4) @(negedge clock);
            roll            = $urandom_range(99);
            rq.cmd          = CMD_ALLOC;
            rq.size_class   = 4'($urandom());
            rq.free_address = $urandom();
            if (roll < 45 || (roll < 85 && live_objects.size() == 0)) begin
               // mostly small slabs so that they fill up
               pick = $urandom_range(99);
               if (pick < 70)
                  rq.size_class = 4'($urandom_range(NUM_CLASSES - 3, NUM_CLASSES));
               else if (pick < 95)
                  rq.size_class = 4'($urandom_range(1, NUM_CLASSES));
            end else if (roll < 85) begin
               // release an object handed out earlier, sometimes unaligned
               idx = $urandom_range(live_objects.size() - 1);
               sl  = live_objects[idx];
               live_objects.delete(idx);
               rq.cmd          = CMD_FREE;
               rq.free_address = base_model + (sl.slab << SLAB_BYTES_LOG2)
                               + (sl.obj << (sl.slab + 1));
               if ($urandom_range(3) == 0)
                  rq.free_address += $urandom_range((1 << (sl.slab + 1)) - 1);
            end else begin
               // stray frees: anywhere, around the edges, or any in-region byte
               rq.cmd = CMD_FREE;
               case ($urandom_range(3))
                  0: ;
                  1: rq.free_address = base_model + REGION_BYTES + $urandom_range(15);
                  2: rq.free_address = base_model - 1 - $urandom_range(15);
                  default: rq.free_address = base_model + $urandom_range(REGION_BYTES - 1);
               endcase
            end
            pending_requests.push_back(rq);
         end
         drain_requests();
      end

      if (expected_responses.size() != 0)
         flag_mismatch($sformatf("%0d responses never arrived", expected_responses.size()));
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Some tests failed");
      $finish;
   end

endmodule
